@@ rtl/triangle_midpoint_subdivider_assert.svh @@
// Assertion macros for the midpoint subdivider.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDER_ASSERT_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TMS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The expression holds on every clock edge.
`define TMS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

@@ rtl/tms_pkg.sv @@
package tms_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int MAX_EDGES    = 8192;   // power of two: probe address wraps
	localparam int COORD_BITS   = 24;

	localparam int VA_W    = $clog2(MAX_VERTICES);
	localparam int EDGE_AW = $clog2(MAX_EDGES);
	localparam int BCNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
	localparam int VIDX_W  = 14;
	localparam int KEY_W   = 2 * VA_W;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_TRI   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [2:0] KIND_LOADED  = 3'd0;
	localparam logic [2:0] KIND_MIDPT   = 3'd1;
	localparam logic [2:0] KIND_TRI     = 3'd2;
	localparam logic [2:0] KIND_SKIPPED = 3'd3;
	localparam logic [2:0] KIND_REFUSED = 3'd4;
	localparam logic [2:0] KIND_CLEARED = 3'd5;

	typedef struct packed {
		logic              vld;
		logic [KEY_W-1:0]  key;
		logic [VIDX_W-1:0] idx;
	} edge_ent_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
	} pos_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [VIDX_W-1:0] vidx;
		pos_t              pos;
		logic [VIDX_W-1:0] t0;
		logic [VIDX_W-1:0] t1;
		logic [VIDX_W-1:0] t2;
		logic              last;
	} res_t;

	function automatic logic [KEY_W-1:0] edge_key(logic [VA_W-1:0] u, logic [VA_W-1:0] v);
		return (u < v) ? {u, v} : {v, u};
	endfunction

	function automatic logic [EDGE_AW-1:0] edge_hash(logic [KEY_W-1:0] k);
		return EDGE_AW'(k) ^ EDGE_AW'(k >> EDGE_AW);
	endfunction

	function automatic logic [COORD_BITS-1:0] mid_coord(logic [COORD_BITS-1:0] p,
		logic [COORD_BITS-1:0] q);
		logic [COORD_BITS:0] s;
		s = {p[COORD_BITS-1], p} + {q[COORD_BITS-1], q};
		return s[COORD_BITS:1];
	endfunction

endpackage

@@ rtl/triangle_midpoint_subdivider.sv @@
// One pass of 1-to-4 midpoint subdivision. Load base vertices (mode 0), then send
// triangles (mode 1). Each triangle yields up to three new midpoint vertices (one per
// edge not seen before) and four triangles, the last one flagged with last. Mode 2
// empties every store. For a triangle, each edge in turn is probed in the edge table
// and, if it is new, its midpoint takes two base-position memory reads and the output
// write; the four triangles follow. The edge table is an open-addressed hash memory
// with linear probing; long probe chains on a crowded table add one probe per occupied
// slot passed. After reset and after every clear item the table is swept, one entry
// per cycle, during which no transaction is accepted. A waiting result stalls the
// next result write and the acceptance of new items; probes and position reads go on
// behind it.
`include "triangle_midpoint_subdivider_assert.svh"

module triangle_midpoint_subdivider
	import tms_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic [VA_W-1:0]              corner_a,
	input  logic [VA_W-1:0]              corner_b,
	input  logic [VA_W-1:0]              corner_c,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   kind,
	output logic [VIDX_W-1:0]            vertex_index,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic signed [COORD_BITS-1:0] out_z,
	output logic [VIDX_W-1:0]            tri_first,
	output logic [VIDX_W-1:0]            tri_second,
	output logic [VIDX_W-1:0]            tri_third,
	output logic                         last
);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,   // sweeping the edge table
		ST_IDLE  = 8'b0000_0010,
		ST_PROBE = 8'b0000_0100,   // read edge entry at h_q
		ST_CMP   = 8'b0000_1000,   // entry data back: hit, miss or next slot
		ST_POSU  = 8'b0001_0000,   // first endpoint position back
		ST_POSV  = 8'b0010_0000,   // second endpoint position back
		ST_MID   = 8'b0100_0000,   // emit midpoint vertex
		ST_TRI   = 8'b1000_0000    // emit the four triangles
	} state_t;

	// control state
	state_t               st_q;
	logic [BCNT_W-1:0]    base_cnt_q;
	logic [VIDX_W-1:0]    next_new_q;
	logic [ECNT_W-1:0]    edges_used_q;
	logic                 tri_seen_q;
	logic                 out_valid_q;
	logic [1:0]           e_q;       // edge in work: 0 ab, 1 bc, 2 ca
	logic [1:0]           t_q;       // triangle being emitted
	logic [EDGE_AW-1:0]   clr_q;

	// payload state
	logic [VA_W-1:0]      a_q, b_q, c_q;
	logic [KEY_W-1:0]     key_q;
	logic [EDGE_AW-1:0]   h_q;
	logic [VIDX_W-1:0]    ab_q, bc_q, ca_q;
	logic [VIDX_W-1:0]    mid_idx_q;
	pos_t                 pu_q, pv_q;
	res_t                 res_q;

	// memories
	edge_ent_t            edge_mem [MAX_EDGES];
	pos_t                 pos_mem  [MAX_VERTICES];
	edge_ent_t            e_rd_q;
	pos_t                 p_rd_q;

	logic                 can_load;
	logic                 acc;
	logic                 e_we;
	logic [EDGE_AW-1:0]   e_waddr;
	edge_ent_t            e_wdata;
	logic                 p_re;
	logic [VA_W-1:0]      p_raddr;
	logic [VA_W-1:0]      cur_u, cur_v, nxt_u, nxt_v;
	logic [KEY_W-1:0]     key0, nxt_key;
	logic                 hit;
	logic                 corner_bad;
	logic                 no_room;
	logic                 emit;
	res_t                 res_d;

	assign can_load = !out_valid_q || !out_stall;
	assign in_stall = !((st_q == ST_IDLE) && can_load);
	assign acc      = in_valid && !in_stall;

	// endpoints of the current and the following edge
	always_comb begin
		cur_u = a_q;
		cur_v = b_q;
		nxt_u = b_q;
		nxt_v = c_q;
		case (e_q)
			2'd0: begin
				cur_u = a_q; cur_v = b_q; nxt_u = b_q; nxt_v = c_q;
			end
			2'd1: begin
				cur_u = b_q; cur_v = c_q; nxt_u = c_q; nxt_v = a_q;
			end
			default: begin
				cur_u = c_q; cur_v = a_q; nxt_u = a_q; nxt_v = b_q;
			end
		endcase
	end

	assign key0    = edge_key(corner_a, corner_b);
	assign nxt_key = edge_key(nxt_u, nxt_v);
	assign hit     = e_rd_q.vld && (e_rd_q.key == key_q);

	assign corner_bad = ({1'b0, corner_a} >= base_cnt_q) || ({1'b0, corner_b} >= base_cnt_q)
		|| ({1'b0, corner_c} >= base_cnt_q);
	assign no_room = ((ECNT_W+1)'(edges_used_q) + (ECNT_W+1)'(3) > (ECNT_W+1)'(MAX_EDGES))
		|| ((VIDX_W+1)'(next_new_q) + (VIDX_W+1)'(3)
			> (VIDX_W+1)'(MAX_VERTICES + MAX_EDGES));

	// memory write / read control
	always_comb begin
		e_we    = 1'b0;
		e_waddr = h_q;
		e_wdata = '{vld: 1'b1, key: key_q, idx: next_new_q};
		p_re    = 1'b0;
		p_raddr = cur_u;
		if (st_q == ST_CLEAR) begin
			e_we    = 1'b1;
			e_waddr = clr_q;
			e_wdata = '0;
		end else if ((st_q == ST_CMP) && !hit && !e_rd_q.vld) begin
			e_we    = 1'b1;
			p_re    = 1'b1;
		end else if (st_q == ST_POSU) begin
			p_re    = 1'b1;
			p_raddr = cur_v;
		end
	end

	always_ff @(posedge clk) begin
		if (e_we)
			edge_mem[e_waddr] <= e_wdata;
		if (st_q == ST_PROBE)
			e_rd_q <= edge_mem[h_q];
	end

	always_ff @(posedge clk) begin
		if (acc && (mode == MODE_LOAD) && !tri_seen_q
			&& (base_cnt_q != BCNT_W'(MAX_VERTICES)))
			pos_mem[base_cnt_q[VA_W-1:0]] <= '{x: pos_x, y: pos_y, z: pos_z};
		if (p_re)
			p_rd_q <= pos_mem[p_raddr];
	end

	// result selection
	always_comb begin
		emit  = 1'b0;
		res_d = '0;
		if (acc) begin
			emit = 1'b1;
			res_d.last = 1'b1;
			unique case (mode)
				MODE_LOAD: begin
					if (tri_seen_q || (base_cnt_q == BCNT_W'(MAX_VERTICES))) begin
						res_d.kind = KIND_REFUSED;
					end else begin
						res_d.kind = KIND_LOADED;
						res_d.vidx = VIDX_W'(base_cnt_q);
					end
				end
				MODE_TRI: begin
					if (corner_bad) begin
						res_d.kind = KIND_SKIPPED;
					end else if (no_room) begin
						res_d.kind = KIND_REFUSED;
					end else begin
						emit = 1'b0;
					end
				end
				MODE_CLEAR: res_d.kind = KIND_CLEARED;
				default:    res_d.kind = KIND_REFUSED;
			endcase
		end else if ((st_q == ST_MID) && can_load) begin
			emit       = 1'b1;
			res_d.kind = KIND_MIDPT;
			res_d.vidx = mid_idx_q;
			res_d.pos  = '{x: mid_coord(pu_q.x, pv_q.x), y: mid_coord(pu_q.y, pv_q.y),
				z: mid_coord(pu_q.z, pv_q.z)};
		end else if ((st_q == ST_TRI) && can_load) begin
			emit       = 1'b1;
			res_d.kind = KIND_TRI;
			case (t_q)
				2'd0: begin
					res_d.t0 = VIDX_W'(a_q); res_d.t1 = ab_q; res_d.t2 = ca_q;
				end
				2'd1: begin
					res_d.t0 = ab_q; res_d.t1 = VIDX_W'(b_q); res_d.t2 = bc_q;
				end
				2'd2: begin
					res_d.t0 = ca_q; res_d.t1 = bc_q; res_d.t2 = VIDX_W'(c_q);
				end
				default: begin
					res_d.t0 = ab_q; res_d.t1 = bc_q; res_d.t2 = ca_q;
					res_d.last = 1'b1;
				end
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_CLEAR;
			base_cnt_q   <= '0;
			next_new_q   <= '0;
			edges_used_q <= '0;
			tri_seen_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			e_q          <= '0;
			t_q          <= '0;
			clr_q        <= '0;
		end else begin
			out_valid_q <= emit || (out_valid_q && out_stall);
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == EDGE_AW'(MAX_EDGES - 1))
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc) begin
						unique case (mode)
							MODE_LOAD: begin
								if (!tri_seen_q && (base_cnt_q != BCNT_W'(MAX_VERTICES))) begin
									base_cnt_q <= base_cnt_q + 1'b1;
									next_new_q <= VIDX_W'(base_cnt_q) + 1'b1;
								end
							end
							MODE_TRI: begin
								tri_seen_q <= 1'b1;
								if (!corner_bad && !no_room) begin
									e_q  <= '0;
									st_q <= ST_PROBE;
								end
							end
							MODE_CLEAR: begin
								base_cnt_q   <= '0;
								next_new_q   <= '0;
								edges_used_q <= '0;
								tri_seen_q   <= 1'b0;
								clr_q        <= '0;
								st_q         <= ST_CLEAR;
							end
							default: ;
						endcase
					end
				end
				ST_PROBE: st_q <= ST_CMP;
				ST_CMP: begin
					if (hit) begin
						if (e_q == 2'd2) begin
							t_q  <= '0;
							st_q <= ST_TRI;
						end else begin
							e_q  <= e_q + 1'b1;
							st_q <= ST_PROBE;
						end
					end else if (!e_rd_q.vld) begin
						edges_used_q <= edges_used_q + 1'b1;
						next_new_q   <= next_new_q + 1'b1;
						st_q         <= ST_POSU;
					end else begin
						st_q <= ST_PROBE;
					end
				end
				ST_POSU: st_q <= ST_POSV;
				ST_POSV: st_q <= ST_MID;
				ST_MID: begin
					if (can_load) begin
						if (e_q == 2'd2) begin
							t_q  <= '0;
							st_q <= ST_TRI;
						end else begin
							e_q  <= e_q + 1'b1;
							st_q <= ST_PROBE;
						end
					end
				end
				ST_TRI: begin
					if (can_load) begin
						t_q <= t_q + 1'b1;
						if (t_q == 2'd3)
							st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (emit)
			res_q <= res_d;
		if (acc) begin
			a_q   <= corner_a;
			b_q   <= corner_b;
			c_q   <= corner_c;
			key_q <= key0;
			h_q   <= edge_hash(key0);
		end
		if (st_q == ST_CMP) begin
			if (hit || !e_rd_q.vld) begin
				case (e_q)
					2'd0:    ab_q <= hit ? e_rd_q.idx : next_new_q;
					2'd1:    bc_q <= hit ? e_rd_q.idx : next_new_q;
					default: ca_q <= hit ? e_rd_q.idx : next_new_q;
				endcase
			end
			if (!hit && !e_rd_q.vld)
				mid_idx_q <= next_new_q;
			if (hit) begin
				key_q <= nxt_key;
				h_q   <= edge_hash(nxt_key);
			end else if (e_rd_q.vld) begin
				h_q <= h_q + 1'b1;
			end
		end
		if (st_q == ST_POSU)
			pu_q <= p_rd_q;
		if (st_q == ST_POSV)
			pv_q <= p_rd_q;
		if ((st_q == ST_MID) && can_load) begin
			key_q <= nxt_key;
			h_q   <= edge_hash(nxt_key);
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = res_q.kind;
	assign vertex_index = res_q.vidx;
	assign out_x        = res_q.pos.x;
	assign out_y        = res_q.pos.y;
	assign out_z        = res_q.pos.z;
	assign tri_first    = res_q.t0;
	assign tri_second   = res_q.t1;
	assign tri_third    = res_q.t2;
	assign last         = res_q.last;

	`TMS_ASSERT_IMP(a_acc_idle, in_valid && !in_stall, st_q == ST_IDLE, "accept outside idle")
	`TMS_ASSERT_ALWAYS(a_edge_cap, edges_used_q <= ECNT_W'(MAX_EDGES), "edge table overfull")
	`TMS_ASSERT_ALWAYS(a_idx_sum,
		next_new_q == VIDX_W'(base_cnt_q) + VIDX_W'(edges_used_q), "new index out of step")
	`TMS_ASSERT_IMP(a_emit_room, emit, can_load, "result written over a waiting one")

endmodule

@@ verif/triangle_midpoint_subdivider_tb.sv @@
module triangle_midpoint_subdivider_tb
	import tms_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// cycles with no transaction on either side before giving up; covers the
	// table sweep after reset and after every clear
	localparam int IDLE_LIMIT = 60000;
	localparam int TAIL_CYCLES = 64;
	localparam int IDX_SPACE = MAX_VERTICES + MAX_EDGES;
	localparam logic [1:0] MODE_UNDEF = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// one input transaction; hold_for_drain makes the driver wait until all
	// outstanding results are back before presenting it
	typedef struct {
		logic [1:0]      mode;
		coord_t          x;
		coord_t          y;
		coord_t          z;
		logic [VA_W-1:0] a;
		logic [VA_W-1:0] b;
		logic [VA_W-1:0] c;
		bit              hold_for_drain;
	} mesh_item_t;

	// one result transaction as the block should present it
	typedef struct {
		logic [2:0]        kind;
		logic [VIDX_W-1:0] vidx;
		coord_t            x;
		coord_t            y;
		coord_t            z;
		logic [VIDX_W-1:0] t0;
		logic [VIDX_W-1:0] t1;
		logic [VIDX_W-1:0] t2;
		logic              last;
	} mesh_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [1:0]                   mode = MODE_LOAD;
	logic signed [COORD_BITS-1:0] pos_x = '0;
	logic signed [COORD_BITS-1:0] pos_y = '0;
	logic signed [COORD_BITS-1:0] pos_z = '0;
	logic [VA_W-1:0]              corner_a = '0;
	logic [VA_W-1:0]              corner_b = '0;
	logic [VA_W-1:0]              corner_c = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [2:0]                   kind;
	logic [VIDX_W-1:0]            vertex_index;
	logic signed [COORD_BITS-1:0] out_x;
	logic signed [COORD_BITS-1:0] out_y;
	logic signed [COORD_BITS-1:0] out_z;
	logic [VIDX_W-1:0]            tri_first;
	logic [VIDX_W-1:0]            tri_second;
	logic [VIDX_W-1:0]            tri_third;
	logic                         last;

	triangle_midpoint_subdivider dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.vertex_index (vertex_index),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.tri_first    (tri_first),
		.tri_second   (tri_second),
		.tri_third    (tri_third),
		.last         (last)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------------
	// Shadow of the block's state
	// ---------------------------------------------------------------------
	coord_t  vert_x [MAX_VERTICES];
	coord_t  vert_y [MAX_VERTICES];
	coord_t  vert_z [MAX_VERTICES];
	int      vert_count = 0;
	int      next_vidx = 0;
	int      edge_vidx [int];          // sorted corner pair key -> midpoint index
	int      edge_count = 0;
	bit      saw_triangle = 1'b0;

	mesh_item_t   stim_items [$];
	mesh_result_t pending_results [$];
	int           mismatches = 0;

	function automatic mesh_result_t blank_result(logic [2:0] k);
		mesh_result_t r;
		r.kind = k;
		r.vidx = '0;
		r.x = '0;
		r.y = '0;
		r.z = '0;
		r.t0 = '0;
		r.t1 = '0;
		r.t2 = '0;
		r.last = 1'b0;
		return r;
	endfunction

	// append to the expected result queue
	function automatic void expect_result(mesh_result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// floor of the half sum: arithmetic shift of the exact 25-bit sum
	function automatic coord_t half_sum(coord_t p, coord_t q);
		int s;
		s = int'(p) + int'(q);
		return coord_t'(s >>> 1);
	endfunction

	// look up an edge; on a miss allocate a midpoint and queue its vertex result
	function automatic int lookup_edge(int u, int v);
		int lo, hi, key;
		mesh_result_t r;
		lo = (u < v) ? u : v;
		hi = (u < v) ? v : u;
		key = (lo << VA_W) | hi;
		if (edge_vidx.exists(key))
			return edge_vidx[key];
		r = blank_result(KIND_MIDPT);
		r.vidx = VIDX_W'(next_vidx);
		r.x = half_sum(vert_x[u], vert_x[v]);
		r.y = half_sum(vert_y[u], vert_y[v]);
		r.z = half_sum(vert_z[u], vert_z[v]);
		expect_result(r);
		edge_vidx[key] = next_vidx;
		edge_count++;
		next_vidx++;
		return next_vidx - 1;
	endfunction

	// work out every result one accepted transaction causes
	function automatic void subdivide_expect(mesh_item_t it);
		mesh_result_t r;
		int ia, ib, ic, mab, mbc, mca;
		ia = it.a;
		ib = it.b;
		ic = it.c;
		case (it.mode)
			MODE_LOAD: begin
				if (saw_triangle || vert_count >= MAX_VERTICES) begin
					r = blank_result(KIND_REFUSED);
				end else begin
					vert_x[vert_count] = it.x;
					vert_y[vert_count] = it.y;
					vert_z[vert_count] = it.z;
					r = blank_result(KIND_LOADED);
					r.vidx = VIDX_W'(vert_count);
					vert_count++;
					next_vidx = vert_count;
				end
				expect_result(r);
			end
			MODE_TRI: begin
				saw_triangle = 1'b1;
				// range check wins over the room check
				if (ia >= vert_count || ib >= vert_count || ic >= vert_count) begin
					expect_result(blank_result(KIND_SKIPPED));
				end else if (edge_count + 3 > MAX_EDGES || next_vidx + 3 > IDX_SPACE) begin
					expect_result(blank_result(KIND_REFUSED));
				end else begin
					mab = lookup_edge(ia, ib);
					mbc = lookup_edge(ib, ic);
					mca = lookup_edge(ic, ia);
					r = blank_result(KIND_TRI);
					r.t0 = VIDX_W'(ia);  r.t1 = VIDX_W'(mab); r.t2 = VIDX_W'(mca);
					expect_result(r);
					r.t0 = VIDX_W'(mab); r.t1 = VIDX_W'(ib);  r.t2 = VIDX_W'(mbc);
					expect_result(r);
					r.t0 = VIDX_W'(mca); r.t1 = VIDX_W'(mbc); r.t2 = VIDX_W'(ic);
					expect_result(r);
					r.t0 = VIDX_W'(mab); r.t1 = VIDX_W'(mbc); r.t2 = VIDX_W'(mca);
					expect_result(r);
				end
			end
			MODE_CLEAR: begin
				vert_count = 0;
				next_vidx = 0;
				edge_vidx.delete();
				edge_count = 0;
				saw_triangle = 1'b0;
				expect_result(blank_result(KIND_CLEARED));
			end
			default: expect_result(blank_result(KIND_REFUSED));
		endcase
		pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(COORD_BITS-1){1'b0}}};
			1: return {1'b0, {(COORD_BITS-1){1'b1}}};
			2: return '1;
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic add_item(logic [1:0] m, coord_t x, coord_t y, coord_t z,
		int a, int b, int c, bit drain);
		mesh_item_t it;
		it.mode = m;
		it.x = x;
		it.y = y;
		it.z = z;
		it.a = VA_W'(a);
		it.b = VA_W'(b);
		it.c = VA_W'(c);
		it.hold_for_drain = drain;
		stim_items.insert(stim_items.size(), it);
	endtask

	// unused fields carry random junk so the block has to ignore them
	task automatic add_load(coord_t x, coord_t y, coord_t z);
		add_item(MODE_LOAD, x, y, z, $urandom, $urandom, $urandom, 1'b0);
	endtask

	task automatic add_tri(int a, int b, int c, bit drain = 1'b0);
		add_item(MODE_TRI, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			a, b, c, drain);
	endtask

	task automatic add_clear();
		add_item(MODE_CLEAR, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			$urandom, $urandom, $urandom, 1'b1);
	endtask

	task automatic add_undef();
		add_item(MODE_UNDEF, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			$urandom, $urandom, $urandom, 1'b0);
	endtask

	// random mesh: a few base vertices, then mostly valid triangles over them
	task automatic add_random_mesh(int n_items);
		int nv, pick, k;
		add_clear();
		nv = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 40);
		for (k = 0; k < nv; k++)
			add_load(rand_coord(), rand_coord(), rand_coord());
		for (k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 78)
				add_tri($urandom_range(0, nv - 1), $urandom_range(0, nv - 1),
					$urandom_range(0, nv - 1), k == n_items / 2);
			else if (pick < 88)
				add_tri($urandom_range(0, nv - 1), $urandom % (1 << VA_W),
					$urandom_range(0, nv + 2));
			else if (pick < 94)
				add_load(rand_coord(), rand_coord(), rand_coord());
			else
				add_undef();
		end
	endtask

	// ---------------------------------------------------------------------
	// Driver
	// ---------------------------------------------------------------------
	mesh_item_t drv_item;
	int         drv_gap = 0;
	bit         drv_calm = 1'b0;

	// mostly short gaps, a few long ones; calm stretches have none
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv_gap = 0;
		end else begin
			if ($urandom_range(0, 299) == 0)
				drv_calm = !drv_calm;
			if (in_valid && !in_stall)
				subdivide_expect(drv_item);
			if (!in_valid || !in_stall) begin
				if (drv_gap > 0) begin
					drv_gap--;
					in_valid <= 1'b0;
				end else if (stim_items.size() != 0 &&
					!(stim_items[0].hold_for_drain && pending_results.size() != 0)) begin
					drv_item = stim_items.pop_front();
					mode     <= drv_item.mode;
					pos_x    <= drv_item.x;
					pos_y    <= drv_item.y;
					pos_z    <= drv_item.z;
					corner_a <= drv_item.a;
					corner_b <= drv_item.b;
					corner_c <= drv_item.c;
					in_valid <= 1'b1;
					drv_gap = pick_gap(drv_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor, checker and watchdog
	// ---------------------------------------------------------------------
	int mon_stall = 0;
	bit mon_calm = 1'b0;
	int idle_cycles = 0;

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field,
			got, want);
	endtask

	task automatic check_result();
		mesh_result_t e;
		if (pending_results.size() == 0) begin
			mismatches++;
			$display("%0t: result transaction with nothing expected (kind %0d)",
				$realtime, kind);
			return;
		end
		e = pending_results.pop_front();
		if (kind !== e.kind)         report("kind", 32'(kind), 32'(e.kind));
		if (vertex_index !== e.vidx) report("vertex_index", 32'(vertex_index), 32'(e.vidx));
		if (out_x !== e.x)           report("out_x", 32'(out_x), 32'(e.x));
		if (out_y !== e.y)           report("out_y", 32'(out_y), 32'(e.y));
		if (out_z !== e.z)           report("out_z", 32'(out_z), 32'(e.z));
		if (tri_first !== e.t0)      report("tri_first", 32'(tri_first), 32'(e.t0));
		if (tri_second !== e.t1)     report("tri_second", 32'(tri_second), 32'(e.t1));
		if (tri_third !== e.t2)      report("tri_third", 32'(tri_third), 32'(e.t2));
		if (last !== e.last)         report("last", 32'(last), 32'(e.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			mon_stall = 0;
			idle_cycles = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
				$display("triangle_midpoint_subdivider_tb failed");
				$finish;
			end else begin
				if ($urandom_range(0, 299) == 0)
					mon_calm = !mon_calm;
				if (mon_stall > 0) begin
					mon_stall--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= 1'b0;
					mon_stall = pick_gap(mon_calm);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------------
	initial begin
		int m;

		// directed: coordinate extremes, hits, reversed and degenerate edges
		add_load({1'b0, {(COORD_BITS-1){1'b1}}}, {1'b0, {(COORD_BITS-1){1'b1}}},
			{1'b0, {(COORD_BITS-1){1'b1}}});
		add_load({1'b1, {(COORD_BITS-1){1'b0}}}, {1'b1, {(COORD_BITS-1){1'b0}}},
			{1'b1, {(COORD_BITS-1){1'b0}}});
		add_load('1, '0, coord_t'(1));
		add_load({1'b1, {(COORD_BITS-1){1'b0}}}, {1'b0, {(COORD_BITS-1){1'b1}}}, '1);
		add_load(coord_t'(3), coord_t'(-3), coord_t'(5));
		add_tri(0, 1, 2);
		add_tri(0, 1, 2);              // every edge already in the table
		add_tri(2, 1, 0);              // same edges, reversed order
		add_tri(3, 3, 4);              // degenerate edge
		add_tri(0, 1, (1 << VA_W) - 1);        // corner past the loaded count
		add_tri(5, 0, 0);
		add_tri((1 << VA_W) - 1, (1 << VA_W) - 1, (1 << VA_W) - 1);
		add_load(rand_coord(), rand_coord(), rand_coord());   // load after triangle
		add_undef();
		add_tri(4, 0, 3, 1'b1);        // sender waits for a full drain first
		add_clear();
		add_load(coord_t'(-1), coord_t'(1), coord_t'(0));
		add_tri(0, 0, 0);
		add_tri(1, 0, 0);              // skipped: only one vertex loaded

		// random meshes, about 360 transactions in all
		for (m = 0; m < 8; m++)
			add_random_mesh(25);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_items.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("triangle_midpoint_subdivider_tb passed");
		else
			$display("triangle_midpoint_subdivider_tb failed");
		$finish;
	end

endmodule
